[hw/rtl/sgec_pkg.sv]
// ----------------------------------------------------------------------------
// sgec_pkg
// Shared types and constants for the servo gear and endpoint controller.
// ----------------------------------------------------------------------------
package sgec_pkg;

  // item kinds
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_GEAR  = 2'd1;
  localparam logic [1:0] ACT_SETUP = 2'd2;

  // setup phases
  localparam logic [1:0] PH_OFF    = 2'd0;
  localparam logic [1:0] PH_LEFT   = 2'd1;
  localparam logic [1:0] PH_CENTRE = 2'd2;
  localparam logic [1:0] PH_RIGHT  = 2'd3;

  // gears
  localparam logic [1:0] GEAR_FIRST  = 2'd0;
  localparam logic [1:0] GEAR_SECOND = 2'd1;
  localparam logic [1:0] GEAR_THIRD  = 2'd2;

  localparam logic [1:0] GEAR_COUNT_TWO = 2'd2;
  localparam logic [3:0] ONE_CLICK      = 4'd1;

  // configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_ADDR_W-1:0] CFG_GEARBOX_EN  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEERING_EN = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GEAR_COUNT  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STORED_L    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_STORED_C    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_STORED_R    = 3'd5;

  // endpoint defaults and output width
  localparam int          FIELD_W   = 12;
  localparam logic [11:0] DEF_LEFT  = 12'd900;
  localparam logic [11:0] DEF_CENT  = 12'd1500;
  localparam logic [11:0] DEF_RIGHT = 12'd2100;

  // steering limit
  localparam logic signed [7:0] STEER_MAX = 8'sd100;
  localparam logic signed [7:0] STEER_MIN = -8'sd100;

  // x * mag / 100 as (x * ceil(mag * 2^23 / 100)) >> 23, exact for spans below 2^16
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP_W     = 24;
  localparam int MAG_W       = 7;
  localparam int RECIP_DEPTH = 1 << MAG_W;
  localparam longint Percent = 100;

  typedef logic [RECIP_DEPTH-1:0][RECIP_W-1:0] recip_tbl_t;

  function automatic recip_tbl_t build_recip();
    recip_tbl_t tbl;
    longint     num;
    for (int i = 0; i < RECIP_DEPTH; i++) begin
      num = longint'(i) * (longint'(1) << RECIP_SHIFT) + Percent - 1;
      tbl[i] = RECIP_W'(num / Percent);
    end
    return tbl;
  endfunction

  localparam recip_tbl_t RECIP_TBL = build_recip();

  typedef struct packed {
    logic [1:0]        action;
    logic [3:0]        clicks;
    logic signed [7:0] steering;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pulse_width;
    logic [1:0]  gear;
    logic [1:0]  setup_phase;
    logic        gear_shifted;
    logic        save_request;
    logic [11:0] saved_left;
    logic [11:0] saved_centre;
    logic [11:0] saved_right;
  } out_item_t;

endpackage

[hw/rtl/servo_gear_and_endpoint_controller.sv]
// ----------------------------------------------------------------------------
// servo_gear_and_endpoint_controller
// Servo pulse width from gear endpoints or steering, with endpoint setup.
// ----------------------------------------------------------------------------
// path: an accepted item waits in the input register, then its result is
// registered; a stalled result holds the input register and then in_stall
// throughput: one item per cycle while the result is not stalled; the state
// update between the input register and the result register is combinational
// reset: synchronous, active low; gear 0, setup off, endpoints 900/1500/2100
// ----------------------------------------------------------------------------
module servo_gear_and_endpoint_controller #(
  parameter int PULSE_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  sgec_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output sgec_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [sgec_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [sgec_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import sgec_pkg::*;

  localparam int PB = PULSE_BITS;

  // configuration
  logic          gearbox_en_r, steering_en_r;
  logic [1:0]    gear_count_r;
  logic [PB-1:0] stored_l_r, stored_c_r, stored_r_r;

  // controller state
  logic [1:0]    gear_r, gear_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic          adv_r, adv_nxt;
  logic [PB-1:0] act_l_r, act_c_r, act_rt_r;
  logic [PB-1:0] act_l_nxt, act_c_nxt, act_rt_nxt;
  logic [PB-1:0] cap_l_r, cap_c_r, cap_l_nxt, cap_c_nxt;
  logic [PB-1:0] pulse_r, pulse_nxt;
  logic          persist;
  logic          changed, save;

  // pipeline
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;
  logic      advance;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // steering interpolation
  logic signed [7:0]  steer_in, steer_sat;
  logic               steer_neg;
  logic [MAG_W-1:0]   mag;
  logic [PB:0]        span_lo, span_hi, span;
  logic               span_neg;
  logic [PB-1:0]      span_abs;
  logic [RECIP_W-1:0] recip;
  logic [PB+RECIP_W-1:0] prod;
  logic [PB-1:0]      quot;
  logic [PB-1:0]      interp;

  always_comb begin
    steer_in = s1_item_r.steering;
    if (steer_in > STEER_MAX) begin
      steer_sat = STEER_MAX;
    end else if (steer_in < STEER_MIN) begin
      steer_sat = STEER_MIN;
    end else begin
      steer_sat = steer_in;
    end
    steer_neg = steer_sat[7];
    mag       = steer_neg ? MAG_W'(-steer_sat) : MAG_W'(steer_sat);
  end

  assign span_lo  = {1'b0, act_c_r} - {1'b0, act_l_r};
  assign span_hi  = {1'b0, act_rt_r} - {1'b0, act_c_r};
  assign span     = steer_neg ? span_lo : span_hi;
  assign span_neg = span[PB];
  assign span_abs = span_neg ? PB'(-span) : PB'(span);
  assign recip    = RECIP_TBL[mag];
  assign prod     = {{RECIP_W{1'b0}}, span_abs} * {{PB{1'b0}}, recip};
  assign quot     = PB'(prod >> RECIP_SHIFT);
  assign interp   = (steer_neg ^ span_neg) ? act_c_r - quot : act_c_r + quot;

  // item update
  logic enabled;
  assign enabled = gearbox_en_r || steering_en_r;

  always_comb begin
    gear_nxt   = gear_r;
    phase_nxt  = phase_r;
    adv_nxt    = adv_r;
    act_l_nxt  = act_l_r;
    act_c_nxt  = act_c_r;
    act_rt_nxt = act_rt_r;
    cap_l_nxt  = cap_l_r;
    cap_c_nxt  = cap_c_r;
    pulse_nxt  = pulse_r;
    persist    = 1'b0;
    changed    = 1'b0;
    save       = 1'b0;
    case (s1_item_r.action)
      ACT_TICK: begin
        if (enabled) begin
          if (phase_r != PH_OFF) begin
            pulse_nxt = interp;
            if (adv_r) begin
              adv_nxt = 1'b0;
              case (phase_r)
                PH_LEFT: begin
                  cap_l_nxt = interp;
                  phase_nxt = PH_CENTRE;
                end
                PH_CENTRE: begin
                  cap_c_nxt = interp;
                  if (gearbox_en_r && gear_count_r == GEAR_COUNT_TWO) begin
                    act_l_nxt = cap_l_r;
                    act_c_nxt = interp;
                    persist   = 1'b1;
                    phase_nxt = PH_OFF;
                  end else begin
                    phase_nxt = PH_RIGHT;
                  end
                end
                default: begin
                  act_l_nxt  = cap_l_r;
                  act_c_nxt  = cap_c_r;
                  act_rt_nxt = interp;
                  persist    = 1'b1;
                  phase_nxt  = PH_OFF;
                end
              endcase
            end
          end else if (gearbox_en_r) begin
            case (gear_r)
              GEAR_FIRST:  pulse_nxt = act_l_r;
              GEAR_SECOND: pulse_nxt = act_c_r;
              GEAR_THIRD:  pulse_nxt = act_rt_r;
              default:     pulse_nxt = pulse_r;
            endcase
          end else begin
            pulse_nxt = interp;
          end
        end
      end
      ACT_GEAR: begin
        if (gearbox_en_r) begin
          if (gear_count_r == GEAR_COUNT_TWO) begin
            gear_nxt = (s1_item_r.clicks == ONE_CLICK) ? GEAR_FIRST : GEAR_SECOND;
          end else if (s1_item_r.clicks == ONE_CLICK) begin
            gear_nxt = (gear_r == GEAR_FIRST) ? GEAR_SECOND : GEAR_THIRD;
          end else begin
            gear_nxt = (gear_r == GEAR_THIRD) ? GEAR_SECOND : GEAR_FIRST;
          end
          changed = 1'b1;
        end
      end
      ACT_SETUP: begin
        if (enabled) begin
          if (phase_r == PH_OFF) begin
            act_l_nxt  = PB'(DEF_LEFT);
            act_c_nxt  = PB'(DEF_CENT);
            act_rt_nxt = PB'(DEF_RIGHT);
            phase_nxt  = PH_LEFT;
          end else if (s1_item_r.clicks == ONE_CLICK) begin
            adv_nxt = 1'b1;
          end else begin
            // cancel: back to the stored endpoints
            phase_nxt  = PH_OFF;
            act_l_nxt  = stored_l_r;
            act_c_nxt  = stored_c_r;
            act_rt_nxt = stored_r_r;
          end
        end
      end
      default: begin
      end
    endcase
    save = persist;

    out_item_nxt.pulse_width  = FIELD_W'(pulse_nxt);
    out_item_nxt.gear         = gear_nxt;
    out_item_nxt.setup_phase  = phase_nxt;
    out_item_nxt.gear_shifted = changed;
    out_item_nxt.save_request = save;
    out_item_nxt.saved_left   = FIELD_W'(act_l_nxt);
    out_item_nxt.saved_centre = FIELD_W'(act_c_nxt);
    out_item_nxt.saved_right  = FIELD_W'(act_rt_nxt);
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= (in_valid && !in_stall) || (s1_valid_r && !advance);
      out_valid_r <= advance || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
    if (advance) begin
      cap_l_r <= cap_l_nxt;
      cap_c_r <= cap_c_nxt;
    end
  end

  // state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gearbox_en_r  <= 1'b0;
      steering_en_r <= 1'b0;
      gear_count_r  <= 2'd3;
      stored_l_r    <= PB'(DEF_LEFT);
      stored_c_r    <= PB'(DEF_CENT);
      stored_r_r    <= PB'(DEF_RIGHT);
      gear_r        <= GEAR_FIRST;
      phase_r       <= PH_OFF;
      adv_r         <= 1'b0;
      act_l_r       <= PB'(DEF_LEFT);
      act_c_r       <= PB'(DEF_CENT);
      act_rt_r      <= PB'(DEF_RIGHT);
      pulse_r       <= PB'(DEF_CENT);
    end else begin
      if (advance) begin
        gear_r   <= gear_nxt;
        phase_r  <= phase_nxt;
        adv_r    <= adv_nxt;
        act_l_r  <= act_l_nxt;
        act_c_r  <= act_c_nxt;
        act_rt_r <= act_rt_nxt;
        pulse_r  <= pulse_nxt;
        if (persist) begin
          stored_l_r <= act_l_nxt;
          stored_c_r <= act_c_nxt;
          stored_r_r <= act_rt_nxt;
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_GEARBOX_EN:  gearbox_en_r  <= cfg_wdata[0];
          CFG_STEERING_EN: steering_en_r <= cfg_wdata[0];
          CFG_GEAR_COUNT:  gear_count_r  <= cfg_wdata[1:0];
          CFG_STORED_L: begin
            stored_l_r <= PB'(cfg_wdata);
            act_l_r    <= PB'(cfg_wdata);
          end
          CFG_STORED_C: begin
            stored_c_r <= PB'(cfg_wdata);
            act_c_r    <= PB'(cfg_wdata);
          end
          CFG_STORED_R: begin
            stored_r_r <= PB'(cfg_wdata);
            act_rt_r   <= PB'(cfg_wdata);
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

[hw/rtl/sgec_checker.sv]
// ----------------------------------------------------------------------------
// sgec_checker
// Port-level checks for the servo gear and endpoint controller.
// ----------------------------------------------------------------------------
module sgec_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input sgec_pkg::out_item_t out_data
);
  import sgec_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // gear value 3 does not exist
  a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.gear != 2'd3)
    else $error("gear out of range");

  // a finished setup leaves setup off
  a_save_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.save_request |-> out_data.setup_phase == PH_OFF)
    else $error("save with setup still active");

  // the input only waits behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled with the result side free");

  // nothing is ready to leave right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind servo_gear_and_endpoint_controller sgec_checker u_sgec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
